// ===== rtl/core/mkds_pkg.sv =====
// mkds_pkg: shared types, widths and codes for the multi-key debounce scanner.
// No dependencies; the design files refer to it by scoped names, the testbench imports it.
`timescale 1ns / 1ps

package mkds_pkg;

  localparam int NUM_KEYS  = 8;
  localparam int LEVELS_W  = 8;   // key_levels input field
  localparam int THR_W     = 8;   // debounce_threshold
  localparam int KIU_W     = 4;   // keys_in_use
  localparam int IDX_W     = 4;   // event_key_index
  localparam int KIND_W    = 2;   // event_kind
  localparam int CNT_W     = 8;   // per-key disagreement counter

  localparam int CFG_ADDR_W = 4;
  localparam int CFG_DATA_W = 32;

  // register index, taken from paddr[3:2]
  typedef enum logic [1:0] {
    REG_THRESHOLD     = 2'd0,
    REG_KEYS_IN_USE   = 2'd1,
    REG_PRESSED_LEVEL = 2'd2,
    REG_UNUSED        = 2'd3
  } reg_idx_t;

  typedef enum logic [KIND_W-1:0] {
    EVT_NONE     = 2'd0,
    EVT_PRESSED  = 2'd1,
    EVT_RELEASED = 2'd2,
    EVT_RSVD     = 2'd3
  } evt_kind_t;

  localparam logic [THR_W-1:0] THR_RESET   = 8'd10;
  localparam logic [KIU_W-1:0] KIU_RESET   = 4'd8;
  localparam logic             LEVEL_RESET = 1'b0;

  // per-lane status toward the merge stage
  typedef struct packed {
    logic fire;       // key reaches threshold on this tick
    logic to_pressed; // direction of the change when it fires
  } lane_stat_t;

endpackage

// ===== rtl/core/mkds_in_if.sv =====
// mkds_in_if: input channel of the debounce scanner, one scan tick per transfer.
// Depends on mkds_pkg for the payload width.
`timescale 1ns / 1ps

interface mkds_in_if;
  logic                          valid;
  logic                          ready;
  logic [mkds_pkg::LEVELS_W-1:0] key_levels;

  modport source (output valid, output key_levels, input ready);
  modport sink   (input valid, input key_levels, output ready);
endinterface

// ===== rtl/core/mkds_out_if.sv =====
// mkds_out_if: result channel of the debounce scanner, one result per scan tick.
// Depends on mkds_pkg for the payload widths.
`timescale 1ns / 1ps

interface mkds_out_if;
  logic                        valid;
  logic                        ready;
  logic [mkds_pkg::IDX_W-1:0]  event_key_index;
  logic [mkds_pkg::KIND_W-1:0] event_kind;

  modport source (output valid, output event_key_index, output event_kind, input ready);
  modport sink   (input valid, input event_key_index, input event_kind, output ready);
endinterface

// ===== rtl/core/mkds_lane.sv =====
// mkds_lane: debounce state of one key (stable flag and disagreement counter).
// Depends on mkds_pkg.
`timescale 1ns / 1ps

module mkds_lane (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       level,
  input  logic                       active,
  input  logic                       pressed_level,
  input  logic [mkds_pkg::THR_W-1:0] threshold,
  input  logic                       update,
  output mkds_pkg::lane_stat_t       stat
);

  logic                       stable_r, stable_nxt;
  logic [mkds_pkg::CNT_W-1:0] cnt_r, cnt_nxt;
  logic                       is_pressed;
  logic                       disagree;
  logic [mkds_pkg::CNT_W-1:0] cnt_inc;
  logic                       reach;

  assign is_pressed = (level == pressed_level);
  assign disagree   = active && (is_pressed != stable_r);
  assign cnt_inc    = (cnt_r == {mkds_pkg::CNT_W{1'b1}}) ? cnt_r
                                                          : cnt_r + mkds_pkg::CNT_W'(1);
  assign reach      = (cnt_inc >= threshold);

  assign stat.fire       = disagree && reach;
  assign stat.to_pressed = is_pressed;

  always_comb begin
    stable_nxt = stable_r;
    cnt_nxt    = cnt_r;
    if (update && disagree) begin
      if (reach) begin
        stable_nxt = is_pressed;
        cnt_nxt    = '0;
      end else begin
        cnt_nxt = cnt_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stable_r <= 1'b0;
      cnt_r    <= '0;
    end else begin
      stable_r <= stable_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

// ===== rtl/core/mkds_merge.sv =====
// mkds_merge: priority merge over the key lanes; picks the lowest firing key.
// Depends on mkds_pkg.
`timescale 1ns / 1ps

module mkds_merge (
  input  mkds_pkg::lane_stat_t [mkds_pkg::NUM_KEYS-1:0] stat,
  input  logic [mkds_pkg::KIU_W-1:0]                    count_eff,
  output logic [mkds_pkg::NUM_KEYS-1:0]                 lane_en,
  output logic [mkds_pkg::IDX_W-1:0]                    evt_idx,
  output mkds_pkg::evt_kind_t                           evt_kind
);

  logic found;

  // lanes up to and including the first firing one take the tick
  always_comb begin
    found    = 1'b0;
    evt_idx  = mkds_pkg::IDX_W'(count_eff);
    evt_kind = mkds_pkg::EVT_NONE;
    lane_en  = '0;
    for (int i = 0; i < mkds_pkg::NUM_KEYS; i++) begin
      lane_en[i] = !found;
      if (!found && stat[i].fire) begin
        found    = 1'b1;
        evt_idx  = mkds_pkg::IDX_W'(i);
        evt_kind = stat[i].to_pressed ? mkds_pkg::EVT_PRESSED : mkds_pkg::EVT_RELEASED;
      end
    end
  end

endmodule

// ===== rtl/core/multi_key_debounce_scanner_core.sv =====
// multi_key_debounce_scanner_core: top level with config registers, key lanes,
// merge stage and output register. Depends on mkds_pkg, mkds_in_if, mkds_out_if,
// mkds_lane and mkds_merge.
`timescale 1ns / 1ps

// Counter-based debounce of up to eight keys. Each input transfer is one scan
// tick; every key lane updates its counter in parallel and the merge stage
// reports the lowest-indexed key that changes state (keys above it keep their
// counters for that tick), else EVT_NONE. One result leaves per tick, in the
// cycle after the input transfer. Throughput is one tick per clock while the
// sink is ready: the per-key state updates in the accepting cycle and the single
// output register takes a new result whenever the previous one is transferred in
// the same cycle. Registers at byte addresses 0x0 debounce_threshold, 0x4
// keys_in_use, 0x8 pressed_level; write them only while no tick is outstanding.
module multi_key_debounce_scanner_core (
  input  logic                            clk,
  input  logic                            rst_n,
  mkds_in_if.sink                         in_ch,
  mkds_out_if.source                      out_ch,
  input  logic                            cfg_psel,
  input  logic                            cfg_penable,
  input  logic                            cfg_pwrite,
  input  logic [mkds_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [mkds_pkg::CFG_DATA_W-1:0] cfg_pwdata,
  output logic [mkds_pkg::CFG_DATA_W-1:0] cfg_prdata,
  output logic                            cfg_pready
);

  logic [mkds_pkg::THR_W-1:0] thr_r, thr_nxt;
  logic [mkds_pkg::KIU_W-1:0] kiu_r, kiu_nxt;
  logic                       plevel_r, plevel_nxt;
  mkds_pkg::reg_idx_t         reg_idx;
  logic                       cfg_wr;

  logic [mkds_pkg::KIU_W-1:0]                    count_eff;
  logic [mkds_pkg::NUM_KEYS-1:0]                 active;
  logic [mkds_pkg::NUM_KEYS-1:0]                 lane_en;
  mkds_pkg::lane_stat_t [mkds_pkg::NUM_KEYS-1:0] stat;
  logic [mkds_pkg::IDX_W-1:0]                    evt_idx;
  mkds_pkg::evt_kind_t                           evt_kind;
  logic                                          accept;

  logic                        out_valid_r, out_valid_nxt;
  logic [mkds_pkg::IDX_W-1:0]  out_idx_r;
  logic [mkds_pkg::KIND_W-1:0] out_kind_r;

  // ---- configuration port ----
  assign cfg_pready = 1'b1;
  assign reg_idx    = mkds_pkg::reg_idx_t'(cfg_paddr[3:2]);
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;

  always_comb begin
    thr_nxt    = thr_r;
    kiu_nxt    = kiu_r;
    plevel_nxt = plevel_r;
    if (cfg_wr) begin
      unique case (reg_idx)
        mkds_pkg::REG_THRESHOLD:     thr_nxt    = cfg_pwdata[mkds_pkg::THR_W-1:0];
        mkds_pkg::REG_KEYS_IN_USE:   kiu_nxt    = cfg_pwdata[mkds_pkg::KIU_W-1:0];
        mkds_pkg::REG_PRESSED_LEVEL: plevel_nxt = cfg_pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      mkds_pkg::REG_THRESHOLD:     cfg_prdata = mkds_pkg::CFG_DATA_W'(thr_r);
      mkds_pkg::REG_KEYS_IN_USE:   cfg_prdata = mkds_pkg::CFG_DATA_W'(kiu_r);
      mkds_pkg::REG_PRESSED_LEVEL: cfg_prdata = mkds_pkg::CFG_DATA_W'(plevel_r);
      default:                     cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r    <= mkds_pkg::THR_RESET;
      kiu_r    <= mkds_pkg::KIU_RESET;
      plevel_r <= mkds_pkg::LEVEL_RESET;
    end else begin
      thr_r    <= thr_nxt;
      kiu_r    <= kiu_nxt;
      plevel_r <= plevel_nxt;
    end
  end

  // ---- lanes ----
  assign count_eff = (int'(kiu_r) > mkds_pkg::NUM_KEYS) ? mkds_pkg::KIU_W'(mkds_pkg::NUM_KEYS)
                                                        : kiu_r;
  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign accept      = in_ch.valid && in_ch.ready;

  for (genvar g = 0; g < mkds_pkg::NUM_KEYS; g++) begin : g_lane
    logic lvl;
    if (g < mkds_pkg::LEVELS_W) begin : g_pin
      assign lvl = in_ch.key_levels[g];
    end else begin : g_nopin
      assign lvl = 1'b0;  // keys without an input pin read low
    end
    assign active[g] = (int'(count_eff) > g);

    mkds_lane u_lane (
      .clk           (clk),
      .rst_n         (rst_n),
      .level         (lvl),
      .active        (active[g]),
      .pressed_level (plevel_r),
      .threshold     (thr_r),
      .update        (accept && lane_en[g]),
      .stat          (stat[g])
    );
  end

  mkds_merge u_merge (
    .stat      (stat),
    .count_eff (count_eff),
    .lane_en   (lane_en),
    .evt_idx   (evt_idx),
    .evt_kind  (evt_kind)
  );

  // ---- output register ----
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (accept) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_idx_r  <= evt_idx;
      out_kind_r <= evt_kind;
    end
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.event_key_index = out_idx_r;
  assign out_ch.event_kind      = out_kind_r;

endmodule

// ===== tb/sv/multi_key_debounce_scanner_core_tb.sv =====
// multi_key_debounce_scanner_core_tb: self-checking testbench for the debounce scanner core.
// Depends on mkds_pkg, mkds_in_if, mkds_out_if and the core; a scoreboard model tracks
// per-key stable state and counters, and results are matched in order.
`timescale 1ns / 1ps

module multi_key_debounce_scanner_core_tb;
  import mkds_pkg::*;

  localparam int CYCLE_LIMIT = 300000;
  localparam int HOLDOFF_AT  = 520;   // result count at which the sink stops for a while
  localparam int HOLDOFF_LEN = 200;
  localparam int N_DIR       = 25;

  typedef struct packed {
    logic [IDX_W-1:0] idx;
    evt_kind_t        kind;
  } scan_result_t;

  // one step of the directed sequence: a register write or a scan tick
  typedef struct packed {
    logic                  is_cfg;
    reg_idx_t              reg_sel;
    logic [CFG_DATA_W-1:0] value;
    logic [LEVELS_W-1:0]   levels;
    logic                  typed;
    logic [IDX_W-1:0]      exp_idx;
    evt_kind_t             exp_kind;
  } dir_row_t;

  localparam dir_row_t DIR_ROWS [N_DIR] = '{
    '{1'b0, REG_THRESHOLD,     32'd0,   8'hFF, 1'b1, 4'd8, EVT_NONE},    // all released
    '{1'b0, REG_THRESHOLD,     32'd0,   8'h00, 1'b0, 4'd0, EVT_NONE},
    '{1'b1, REG_THRESHOLD,     32'd0,   8'h00, 1'b0, 4'd0, EVT_NONE},    // zero threshold
    '{1'b0, REG_THRESHOLD,     32'd0,   8'h00, 1'b1, 4'd0, EVT_PRESSED},
    '{1'b0, REG_THRESHOLD,     32'd0,   8'h00, 1'b1, 4'd1, EVT_PRESSED},
    '{1'b0, REG_THRESHOLD,     32'd0,   8'hFF, 1'b0, 4'd0, EVT_NONE},
    '{1'b1, REG_KEYS_IN_USE,   32'd0,   8'h00, 1'b0, 4'd0, EVT_NONE},    // no keys scanned
    '{1'b0, REG_THRESHOLD,     32'd0,   8'h55, 1'b1, 4'd0, EVT_NONE},
    '{1'b0, REG_THRESHOLD,     32'd0,   8'hAA, 1'b1, 4'd0, EVT_NONE},
    '{1'b1, REG_KEYS_IN_USE,   32'd15,  8'h00, 1'b0, 4'd0, EVT_NONE},    // saturates to 8
    '{1'b0, REG_THRESHOLD,     32'd0,   8'h00, 1'b0, 4'd0, EVT_NONE},
    '{1'b0, REG_THRESHOLD,     32'd0,   8'h00, 1'b0, 4'd0, EVT_NONE},
    '{1'b1, REG_PRESSED_LEVEL, 32'd1,   8'h00, 1'b0, 4'd0, EVT_NONE},
    '{1'b0, REG_THRESHOLD,     32'd0,   8'hFF, 1'b0, 4'd0, EVT_NONE},
    '{1'b0, REG_THRESHOLD,     32'd0,   8'h00, 1'b0, 4'd0, EVT_NONE},
    '{1'b1, REG_THRESHOLD,     32'd255, 8'h00, 1'b0, 4'd0, EVT_NONE},
    '{1'b0, REG_THRESHOLD,     32'd0,   8'h80, 1'b0, 4'd0, EVT_NONE},
    '{1'b0, REG_THRESHOLD,     32'd0,   8'h7F, 1'b0, 4'd0, EVT_NONE},
    '{1'b1, REG_THRESHOLD,     32'd3,   8'h00, 1'b0, 4'd0, EVT_NONE},
    // bounce on key 0: count keeps going across agreeing ticks
    '{1'b0, REG_THRESHOLD,     32'd0,   8'h01, 1'b0, 4'd0, EVT_NONE},
    '{1'b0, REG_THRESHOLD,     32'd0,   8'h00, 1'b0, 4'd0, EVT_NONE},
    '{1'b0, REG_THRESHOLD,     32'd0,   8'h01, 1'b0, 4'd0, EVT_NONE},
    '{1'b0, REG_THRESHOLD,     32'd0,   8'h01, 1'b0, 4'd0, EVT_NONE},
    '{1'b0, REG_THRESHOLD,     32'd0,   8'hFF, 1'b0, 4'd0, EVT_NONE},
    '{1'b0, REG_THRESHOLD,     32'd0,   8'h00, 1'b0, 4'd0, EVT_NONE}
  };

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_psel;
  logic                  cfg_penable;
  logic                  cfg_pwrite;
  logic [CFG_ADDR_W-1:0] cfg_paddr;
  logic [CFG_DATA_W-1:0] cfg_pwdata;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic                  cfg_pready;

  mkds_in_if  in_ch ();
  mkds_out_if out_ch ();

  multi_key_debounce_scanner_core dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always #1 clk = ~clk;

  // scoreboard copy of the registers and per-key state
  logic [THR_W-1:0]    thr_cfg;
  logic [KIU_W-1:0]    keys_cfg;
  logic                plevel_cfg;
  logic [NUM_KEYS-1:0] key_stable;
  logic [CNT_W-1:0]    key_count [NUM_KEYS];

  scan_result_t pending_scans [$];
  int           fail_cnt  = 0;
  int           n_sent    = 0;
  int           n_results = 0;
  int           cycle_cnt = 0;
  bit           tx_steady = 1'b0;
  bit           rx_steady = 1'b0;

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // one scan tick: lowest-indexed key that reaches the threshold wins, later keys untouched
  function automatic scan_result_t debounce_tick(input logic [LEVELS_W-1:0] lv);
    int           n_keys;
    int           k;
    logic         now_pressed;
    scan_result_t r;
    n_keys = (keys_cfg > NUM_KEYS) ? NUM_KEYS : int'(keys_cfg);
    r.kind = EVT_NONE;
    for (k = 0; k < n_keys; k++) begin
      now_pressed = (lv[k] == plevel_cfg);
      if (now_pressed != key_stable[k]) begin
        if (key_count[k] != {CNT_W{1'b1}})
          key_count[k] = key_count[k] + 1'b1;
        if (key_count[k] >= thr_cfg) begin
          key_stable[k] = now_pressed;
          key_count[k]  = '0;
          r.kind = now_pressed ? EVT_PRESSED : EVT_RELEASED;
          break;
        end
      end
    end
    r.idx = k[IDX_W-1:0];
    return r;
  endfunction

  task automatic send_tick(input logic [LEVELS_W-1:0] lv, input bit typed,
                           input scan_result_t typed_res);
    int           gap;
    scan_result_t predicted;
    if (n_sent % 40 == 0)
      tx_steady = ($urandom_range(0, 3) == 0);
    gap = tx_steady ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.key_levels <= lv;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    predicted = debounce_tick(lv);
    pending_scans.push_back(typed ? typed_res : predicted);
    n_sent++;
  endtask

  // block is idle once every result is out; a few extra cycles cover the output stage
  task automatic settle();
    in_ch.valid <= 1'b0;
    while (pending_scans.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic cfg_write(input reg_idx_t sel, input logic [CFG_DATA_W-1:0] v);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {sel, 2'b00};
    cfg_pwdata  <= v;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    case (sel)
      REG_THRESHOLD:     thr_cfg    = v[THR_W-1:0];
      REG_KEYS_IN_USE:   keys_cfg   = v[KIU_W-1:0];
      REG_PRESSED_LEVEL: plevel_cfg = v[0];
      default: ;
    endcase
  endtask

  // held key patterns with bounces and stray samples; counters carry across holds
  task automatic run_phase(input int thr, input int kiu, input int lvl, input int n_ticks,
                           input bit pause_mid);
    int                  i;
    int                  hold_left;
    logic [LEVELS_W-1:0] held;
    logic [LEVELS_W-1:0] lv;
    hold_left = 0;
    held      = '0;
    settle();
    cfg_write(REG_THRESHOLD, thr);
    cfg_write(REG_KEYS_IN_USE, kiu);
    cfg_write(REG_PRESSED_LEVEL, lvl);
    for (i = 0; i < n_ticks; i++) begin
      if (hold_left == 0) begin
        if ($urandom_range(0, 1) == 0)
          held = LEVELS_W'($urandom_range(0, 255));
        else
          held = held ^ (8'h01 << $urandom_range(0, 7));
        hold_left = $urandom_range(thr / 2 + 1, 2 * thr + 4);
      end
      lv = held;
      case ($urandom_range(0, 9))
        0: lv = lv ^ (8'h01 << $urandom_range(0, 7));
        1: lv = LEVELS_W'($urandom_range(0, 255));
        default: ;
      endcase
      send_tick(lv, 1'b0, '0);
      hold_left--;
      if (pause_mid && i == n_ticks / 2)
        settle();
    end
  endtask

  initial begin : result_sink
    int           stall;
    scan_result_t exp_res;
    out_ch.ready <= 1'b0;
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      if (n_results % 40 == 0)
        rx_steady = ($urandom_range(0, 3) == 0);
      stall = (n_results == HOLDOFF_AT) ? HOLDOFF_LEN :
              (rx_steady ? 0 : $urandom_range(0, 5));
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
      while (!out_ch.valid) @(posedge clk);
      if (pending_scans.size() == 0) begin
        $error("unexpected transfer: event_key_index %0d event_kind %0d",
               out_ch.event_key_index, out_ch.event_kind);
        fail_cnt++;
      end else begin
        exp_res = pending_scans.pop_front();
        if (out_ch.event_key_index !== exp_res.idx) begin
          $error("event_key_index: expected %0d, actual %0d",
                 exp_res.idx, out_ch.event_key_index);
          fail_cnt++;
        end
        if (out_ch.event_kind !== exp_res.kind) begin
          $error("event_kind: expected %0d, actual %0d", exp_res.kind, out_ch.event_kind);
          fail_cnt++;
        end
      end
      n_results++;
    end
  end

  initial begin : stimulus
    int           i;
    dir_row_t     row;
    scan_result_t typed_res;
    rst_n            <= 1'b0;
    in_ch.valid      <= 1'b0;
    in_ch.key_levels <= '0;
    cfg_psel         <= 1'b0;
    cfg_penable      <= 1'b0;
    cfg_pwrite       <= 1'b0;
    cfg_paddr        <= '0;
    cfg_pwdata       <= '0;
    thr_cfg    = THR_RESET;
    keys_cfg   = KIU_RESET;
    plevel_cfg = LEVEL_RESET;
    key_stable = '0;
    for (i = 0; i < NUM_KEYS; i++)
      key_count[i] = '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (i = 0; i < N_DIR; i++) begin
      row = DIR_ROWS[i];
      if (row.is_cfg) begin
        settle();
        cfg_write(row.reg_sel, row.value);
      end else begin
        typed_res.idx  = row.exp_idx;
        typed_res.kind = row.exp_kind;
        send_tick(row.levels, row.typed, typed_res);
      end
    end

    run_phase(1, 8, 0, 200, 1'b0);
    run_phase(2, 8, 1, 200, 1'b0);
    run_phase(3, 5, 0, 200, 1'b0);
    run_phase(0, 8, 0, 150, 1'b1);
    run_phase(255, 8, 1, 450, 1'b0);
    run_phase(4, 15, 1, 200, 1'b0);
    for (i = 0; i < 3; i++)
      run_phase($urandom_range(0, 6), $urandom_range(0, 15), $urandom_range(0, 1), 140, 1'b0);

    settle();
    repeat (8) @(posedge clk);
    if (fail_cnt == 0 && pending_scans.size() == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/mkds_pkg.sv
rtl/core/mkds_in_if.sv
rtl/core/mkds_out_if.sv
rtl/core/mkds_lane.sv
rtl/core/mkds_merge.sv
rtl/core/multi_key_debounce_scanner_core.sv
tb/sv/multi_key_debounce_scanner_core_tb.sv
